/* rtl/core/bounded_deque_defines.svh */
// Assertion macros for the deque; clk and rst_n come from the scope of use.
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Same-cycle implication.
`define BDQ_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication.
`define BDQ_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

/* rtl/core/bdq_pkg.sv */
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP_FWD   = 3'd4;
    localparam logic [2:0] OP_DUMP_REV   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [2:0] CMD_HOLD       = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;
    localparam logic [2:0] CMD_ROT_LEFT   = 3'd5;
    localparam logic [2:0] CMD_ROT_RIGHT  = 3'd6;

    typedef struct packed {
        logic [2:0] cmd;
        word_t      value;
        word_t      wrap_word;
    } cell_ctl_t;

endpackage

/* rtl/core/bdq_cell.sv */
`timescale 1ns / 1ps

module bdq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  bdq_pkg::cell_ctl_t ctl,
    input  bdq_pkg::word_t    prev_word,
    input  logic              prev_occ,
    input  bdq_pkg::word_t    next_word,
    input  logic              next_occ,
    output bdq_pkg::word_t    word,
    output logic              occ,
    output logic              tail
);
    import bdq_pkg::*;

    word_t word_reg;
    word_t word_next;
    logic  occ_reg;
    logic  occ_next;

    always_comb
    begin
        word_next = word_reg;
        occ_next  = occ_reg;
        unique case (ctl.cmd)
            CMD_PUSH_FRONT:
            begin
                word_next = prev_word;
                occ_next  = prev_occ;
            end
            CMD_PUSH_BACK:
            begin
                if (!occ_reg && prev_occ)
                begin
                    word_next = ctl.value;
                    occ_next  = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                word_next = next_word;
                occ_next  = next_occ;
            end
            CMD_POP_BACK:
            begin
                if (occ_reg && !next_occ)
                begin
                    occ_next = 1'b0;
                end
            end
            CMD_ROT_LEFT:
            begin
                if (occ_reg)
                begin
                    word_next = next_occ ? next_word : ctl.wrap_word;
                end
            end
            CMD_ROT_RIGHT:
            begin
                if (occ_reg)
                begin
                    word_next = prev_word;
                end
            end
            default:
            begin
                word_next = word_reg;
                occ_next  = occ_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign occ  = occ_reg;
    assign tail = occ_reg && !next_occ;

endmodule

/* rtl/core/bounded_deque.sv */
`timescale 1ns / 1ps
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  input   | in_valid  | in_stall  | operation, value
//  output  | out_valid | out_stall | status, front_word, back_word, entry_count,
//          |           |           | element_valid, dumped_word, last
//  Pushes, pops and empty dumps give one output word; the cell row updates in one step.
//  A dump of N elements streams N words, one per cycle unless out_stall holds it, once
//  the dump flag is set; the row rotates once per word and input stalls until it ends.
//  A stalled output word holds the output register and stalls input.
//  Reset empties the deque; stored words need no clearing.

`include "bounded_deque_defines.svh"

module bounded_deque #(
    parameter int DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            operation,
    input  bdq_pkg::word_t        value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output bdq_pkg::word_t        front_word,
    output bdq_pkg::word_t        back_word,
    output logic [5:0]            entry_count,
    output logic                  element_valid,
    output bdq_pkg::word_t        dumped_word,
    output logic                  last
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

    word_t            cell_word [DEPTH];
    logic [DEPTH-1:0] cell_occ;
    logic [DEPTH-1:0] cell_tail;
    cell_ctl_t        ctl;
    word_t            head_in;
    word_t            tail_word;
    word_t            prev_tail_word;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             dumping_reg, dumping_next;
    logic             rev_reg, rev_next;
    logic             out_valid_reg, out_valid_next;
    word_t            hold_front_reg, hold_front_next;
    word_t            hold_back_reg, hold_back_next;
    logic [1:0]       status_reg, status_next;
    word_t            front_reg, front_next;
    word_t            back_reg, back_next;
    logic [5:0]       count_out_reg, count_out_next;
    logic             elem_valid_reg, elem_valid_next;
    word_t            dumped_reg, dumped_next;
    logic             last_reg, last_next;

    logic             out_load;
    logic             accept;
    logic             step;
    logic             empty;
    logic             full;
    logic             single;
    logic             is_push;
    word_t            cur_front;
    logic [CNT_W+5:0] cnt_wide;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            word_t p_word;
            logic  p_occ;
            word_t n_word;
            logic  n_occ;
            if (g == 0)
            begin : g_head
                assign p_word = head_in;
                assign p_occ  = 1'b1;
            end
            else
            begin : g_mid
                assign p_word = cell_word[g-1];
                assign p_occ  = cell_occ[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_end
                assign n_word = '0;
                assign n_occ  = 1'b0;
            end
            else
            begin : g_body
                assign n_word = cell_word[g+1];
                assign n_occ  = cell_occ[g+1];
            end
            bdq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .prev_word (p_word),
                .prev_occ  (p_occ),
                .next_word (n_word),
                .next_occ  (n_occ),
                .word      (cell_word[g]),
                .occ       (cell_occ[g]),
                .tail      (cell_tail[g])
            );
        end
    endgenerate

    always_comb
    begin
        tail_word      = '0;
        prev_tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_word = tail_word | (cell_word[i] & {WORD_W{cell_tail[i]}});
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            prev_tail_word = prev_tail_word | (cell_word[i] & {WORD_W{cell_tail[i+1]}});
        end
    end

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == DEPTH_CNT);
    assign single    = (count_reg == ONE_CNT);
    assign is_push   = (operation == OP_PUSH_FRONT) || (operation == OP_PUSH_BACK);
    assign cur_front = empty ? word_t'(0) : cell_word[0];
    assign out_load  = !out_valid_reg || !out_stall;
    assign in_stall  = dumping_reg || !out_load;
    assign accept    = in_valid && !in_stall;
    assign step      = dumping_reg && out_load;
    assign head_in   = (ctl.cmd == CMD_ROT_RIGHT) ? tail_word : value;

    always_comb
    begin
        ctl.cmd         = CMD_HOLD;
        ctl.value       = value;
        ctl.wrap_word   = cell_word[0];
        count_next      = count_reg;
        left_next       = left_reg;
        dumping_next    = dumping_reg;
        rev_next        = rev_reg;
        hold_front_next = hold_front_reg;
        hold_back_next  = hold_back_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        elem_valid_next = elem_valid_reg;
        dumped_next     = dumped_reg;
        last_next       = last_reg;

        if (accept)
        begin
            out_valid_next  = 1'b1;
            status_next     = ST_OK;
            front_next      = cur_front;
            back_next       = tail_word;
            elem_valid_next = 1'b0;
            dumped_next     = '0;
            last_next       = 1'b1;
            unique case (operation) inside
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + ONE_CNT;
                        if (operation == OP_PUSH_FRONT)
                        begin
                            ctl.cmd    = CMD_PUSH_FRONT;
                            front_next = value;
                            back_next  = empty ? value : tail_word;
                        end
                        else
                        begin
                            ctl.cmd    = CMD_PUSH_BACK;
                            front_next = empty ? value : cell_word[0];
                            back_next  = value;
                        end
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - ONE_CNT;
                        if (operation == OP_POP_FRONT)
                        begin
                            ctl.cmd    = CMD_POP_FRONT;
                            front_next = single ? word_t'(0) : cell_word[1];
                            back_next  = single ? word_t'(0) : tail_word;
                        end
                        else
                        begin
                            ctl.cmd    = CMD_POP_BACK;
                            front_next = single ? word_t'(0) : cell_word[0];
                            back_next  = single ? word_t'(0) : prev_tail_word;
                        end
                    end
                end
                OP_DUMP_FWD, OP_DUMP_REV:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_valid_next  = 1'b0;
                        dumping_next    = 1'b1;
                        left_next       = count_reg;
                        rev_next        = (operation == OP_DUMP_REV);
                        hold_front_next = cell_word[0];
                        hold_back_next  = tail_word;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
        else if (step)
        begin
            // emit one word, rotate the row toward the tap
            ctl.cmd         = rev_reg ? CMD_ROT_RIGHT : CMD_ROT_LEFT;
            out_valid_next  = 1'b1;
            status_next     = ST_OK;
            front_next      = hold_front_reg;
            back_next       = hold_back_reg;
            elem_valid_next = 1'b1;
            dumped_next     = rev_reg ? tail_word : cell_word[0];
            last_next       = (left_reg == ONE_CNT);
            left_next       = left_reg - ONE_CNT;
            if (left_reg == ONE_CNT)
            begin
                dumping_next = 1'b0;
            end
        end
        else if (out_load)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign cnt_wide       = {6'd0, count_next};
    assign count_out_next = cnt_wide[5:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            left_reg      <= '0;
            dumping_reg   <= 1'b0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            left_reg      <= left_next;
            dumping_reg   <= dumping_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_front_reg <= hold_front_next;
        hold_back_reg  <= hold_back_next;
        status_reg     <= status_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        elem_valid_reg <= elem_valid_next;
        dumped_reg     <= dumped_next;
        last_reg       <= last_next;
        if (accept || step)
        begin
            count_out_reg <= count_out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign front_word    = front_reg;
    assign back_word     = back_reg;
    assign entry_count   = count_out_reg;
    assign element_valid = elem_valid_reg;
    assign dumped_word   = dumped_reg;
    assign last          = last_reg;

    `BDQ_ASSERT_IMP(a_occ_matches_count, 1'b1, $countones(cell_occ) == count_reg)
    `BDQ_ASSERT_IMP(a_count_bounded, 1'b1, count_reg <= DEPTH_CNT)
    `BDQ_ASSERT_IMP(a_mid_dump_only, out_valid_reg && !last_reg, dumping_reg)
    `BDQ_ASSERT_NXT(a_dump_ends, step && (left_reg == ONE_CNT), !dumping_reg)
    `BDQ_ASSERT_NXT(a_full_push_holds, accept && full && is_push, $stable(count_reg))

endmodule

/* dv/bounded_deque_checker.sv */
`timescale 1ns / 1ps

module bounded_deque_checker #(
    parameter int DEPTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  logic [2:0]     operation,
    input  bdq_pkg::word_t value,
    input  logic           out_valid,
    input  logic           out_stall,
    input  logic [1:0]     status,
    input  bdq_pkg::word_t front_word,
    input  bdq_pkg::word_t back_word,
    input  logic [5:0]     entry_count,
    input  logic           element_valid,
    input  bdq_pkg::word_t dumped_word,
    input  logic           last,
    output int             fail_count,
    output int             pending,
    output int             results_checked,
    output int             dump_elements,
    output int             error_words
);
    import bdq_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        word_t      front;
        word_t      back;
        logic [5:0] count;
        logic       elem_valid;
        word_t      elem;
        logic       last;
    } deque_view_t;

    deque_view_t expected_views[$];

    word_t ring [DEPTH];
    int    head;
    int    fill;

    int mismatches  = 0;
    int checked     = 0;
    int dumped      = 0;
    int rejects     = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic deque_view_t view_now(input logic [1:0] st, input logic ev,
                                             input word_t elem, input logic lst);
        deque_view_t v;
        v.status     = st;
        v.front      = '0;
        v.back       = '0;
        if (fill > 0)
        begin
            v.front = ring[head];
            v.back  = ring[(head + fill - 1) % DEPTH];
        end
        v.count      = 6'(fill);
        v.elem_valid = ev;
        v.elem       = elem;
        v.last       = lst;
        return v;
    endfunction

    task automatic apply_op(input logic [2:0] op, input word_t v);
        logic [1:0] st;
        bit         streamed;
        int         k;
        int         off;
        st       = ST_OK;
        streamed = 1'b0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill >= DEPTH)
                    st = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                begin
                    head       = (head + DEPTH - 1) % DEPTH;
                    ring[head] = v;
                    fill++;
                end
                else
                begin
                    ring[(head + fill) % DEPTH] = v;
                    fill++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill == 0)
                    st = ST_EMPTY;
                else
                begin
                    if (op == OP_POP_FRONT)
                        head = (head + 1) % DEPTH;
                    fill--;
                end
            end
            OP_DUMP_FWD, OP_DUMP_REV:
            begin
                if (fill == 0)
                    st = ST_EMPTY;
                else
                begin
                    streamed = 1'b1;
                    for (k = 0; k < fill; k++)
                    begin
                        off = (op == OP_DUMP_FWD) ? k : (fill - 1 - k);
                        expected_views.push_back(view_now(ST_OK, 1'b1,
                            ring[(head + off) % DEPTH], k == fill - 1));
                    end
                end
            end
            default: ;
        endcase
        if (st != ST_OK)
            rejects++;
        if (!streamed)
            expected_views.push_back(view_now(st, 1'b0, '0, 1'b1));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deque_view_t want;
        if (!rst_n)
        begin
            expected_views.delete();
            head = 0;
            fill = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_op(operation, value);
            if (out_valid && !out_stall)
            begin
                if (expected_views.size() == 0)
                    report_mismatch($sformatf(
                        "word with nothing expected: status %0d count %0d dumped %h",
                        status, entry_count, dumped_word));
                else
                begin
                    want = expected_views.pop_front();
                    check_field("status", 32'(status), 32'(want.status));
                    check_field("front_word", front_word, want.front);
                    check_field("back_word", back_word, want.back);
                    check_field("entry_count", 32'(entry_count), 32'(want.count));
                    check_field("element_valid", 32'(element_valid),
                                32'(want.elem_valid));
                    check_field("dumped_word", dumped_word, want.elem);
                    check_field("last", 32'(last), 32'(want.last));
                    checked++;
                    if (want.elem_valid)
                        dumped++;
                end
            end
        end
        pending         <= expected_views.size();
        fail_count      <= mismatches;
        results_checked <= checked;
        dump_elements   <= dumped;
        error_words     <= rejects;
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import bdq_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_stall;
    logic [2:0] operation     = '0;
    word_t      value         = '0;
    logic       out_valid;
    logic       out_stall     = 1'b0;
    logic [1:0] status;
    word_t      front_word;
    word_t      back_word;
    logic [5:0] entry_count;
    logic       element_valid;
    word_t      dumped_word;
    logic       last;

    int fail_count;
    int pending;
    int results_checked;
    int dump_elements;
    int error_words;

    int cycle_count = 0;
    int items_sent  = 0;
    bit no_idle     = 1'b0;

    bounded_deque #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .front_word    (front_word),
        .back_word     (back_word),
        .entry_count   (entry_count),
        .element_valid (element_valid),
        .dumped_word   (dumped_word),
        .last          (last)
    );

    bounded_deque_checker #(.DEPTH(DEPTH)) chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .front_word      (front_word),
        .back_word       (back_word),
        .entry_count     (entry_count),
        .element_valid   (element_valid),
        .dumped_word     (dumped_word),
        .last            (last),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .dump_elements   (dump_elements),
        .error_words     (error_words)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    function automatic int draw_idle();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 15);
        return 0;
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input logic [2:0] op, input word_t v);
        int gap;
        gap = draw_idle();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        value     <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin : sink
        int n;
        while (!rst_n) @(posedge clk);
        forever
        begin
            n = draw_idle();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int         i;
        int         r;
        int         counted;
        logic [2:0] op;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_word(OP_POP_FRONT, 32'sh1234_5678);
        send_word(OP_POP_BACK, -1);
        send_word(OP_DUMP_FWD, '0);
        send_word(OP_DUMP_REV, '0);
        send_word(OP_SPARE_6, 32'sh7fff_ffff);
        send_word(OP_SPARE_7, 32'sh8000_0000);
        send_word(OP_PUSH_FRONT, 32'sh8000_0000);
        send_word(OP_PUSH_BACK, 32'sh7fff_ffff);
        send_word(OP_PUSH_FRONT, '0);
        send_word(OP_PUSH_BACK, -1);
        send_word(OP_PUSH_FRONT, 32'shaaaa_aaaa);
        send_word(OP_PUSH_BACK, 32'sh5555_5555);
        send_word(OP_DUMP_FWD, '0);
        send_word(OP_DUMP_REV, -1);
        send_word(OP_SPARE_6, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK, '0);
        send_word(OP_DUMP_FWD, '0);
        send_word(OP_POP_BACK, '0);
        send_word(OP_POP_FRONT, '0);
        wait_drained();

        // fill past full, dump both ways at max depth
        for (i = 0; i < DEPTH + 2; i++)
            send_word($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_word());
        send_word(OP_DUMP_FWD, rand_word());
        send_word(OP_DUMP_REV, rand_word());
        wait_drained();

        // drain past empty
        for (i = 0; i < DEPTH + 2; i++)
            send_word($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, rand_word());
        send_word($urandom_range(0, 1) ? OP_DUMP_REV : OP_DUMP_FWD, rand_word());

        counted = 0;
        while (counted < 12)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (r < 72)
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            else if (r < 90)
                op = $urandom_range(0, 1) ? OP_DUMP_REV : OP_DUMP_FWD;
            else
                op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
            no_idle = (counted < 4);
            send_word(op, rand_word());
            if (op != OP_SPARE_6 && op != OP_SPARE_7)
                counted++;
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);

        $display("sent %0d words: %0d results checked, %0d dumped elements,",
                 items_sent, results_checked, dump_elements);
        $display("%0d full/empty rejects", error_words);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque.sv
dv/bounded_deque_checker.sv
dv/tb_top.sv
